[hw/rtl/mbrc_pkg.sv]
// package for the modbus rtu response checker
// shared constants, word types, status codes and the crc-16 byte update
// no dependencies
package mbrc_pkg;

  // largest register count a read response may carry
  localparam int MAX_REGISTERS = 32;

  // register count width and frame length width
  localparam int CNT_W = 6;
  localparam int LEN_W = 7;

  // address width of the value store
  localparam int RAM_AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

  // frame lengths: read response is READ_BASE_LEN + 2n, write echo is ECHO_LEN
  localparam logic [LEN_W-1:0] READ_BASE_LEN = LEN_W'(5);
  localparam logic [LEN_W-1:0] ECHO_LEN      = LEN_W'(8);
  localparam logic [LEN_W-1:0] VALUE_START   = LEN_W'(3);

  // crc constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // exception function codes lie strictly between these two
  localparam logic [7:0] EXC_BASE  = 8'h80;
  localparam logic [7:0] EXC_LIMIT = 8'h91;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEVICE_ID         = 2'd0,
    CFG_EXPECTED_FUNCTION = 2'd1,
    CFG_REGISTER_COUNT    = 2'd2,
    CFG_RESPONSE_KIND     = 2'd3
  } cfg_idx_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_SHORT      = 3'd2,
    ST_CRC_ERR    = 3'd3,
    ST_WRONG_ID   = 3'd4,
    ST_EXCEPTION  = 3'd5,
    ST_WRONG_FUNC = 3'd6
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } ctrl_state_e;

  // input word
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic        has_value;
    logic [4:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  exception_code;
    logic        last;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic load_value;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic single;
    logic multi;
    logic idx_last;
  } dp_status_t;

  // modbus crc-16 over one byte, reflected polynomial
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/mbrc_ram.sv]
// generic single write port ram with registered read
// holds one byte lane of the register value store
// no dependencies
module mbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mbrc_datapath.sv]
// datapath of the modbus rtu response checker
// frame registers, crc, frame checks, value store and result register
// depends on mbrc_pkg and mbrc_ram
module mbrc_datapath import mbrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  in_word_t         in_data_i,
  input  logic [7:0]       device_id_i,
  input  logic [7:0]       expected_function_i,
  input  logic [CNT_W-1:0] register_count_i,
  input  logic             response_kind_i,
  output out_word_t        out_data_o
);

  // frame state
  logic [LEN_W-1:0] count_q, count_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       func_byte_q, func_byte_d;
  logic [7:0]       id_byte_q, id_byte_d;
  logic [15:0]      rx_crc_q, rx_crc_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  out_word_t        out_q, out_d;

  logic [CNT_W-1:0] reg_n;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] count_next;
  logic [LEN_W-1:0] value_off;
  logic [CNT_W-1:0] value_slot;
  logic             hi_we, lo_we;
  logic [7:0]       hi_rd, lo_rd;
  logic             finish;
  logic             single, multi;
  status_e          res_status;
  logic [3:0]       res_exc;
  logic [15:0]      crc_wire;

  // effective register count and expected length
  assign reg_n     = (register_count_i > CNT_W'(MAX_REGISTERS)) ? CNT_W'(MAX_REGISTERS)
                                                                : register_count_i;
  assign frame_len = response_kind_i ? ECHO_LEN : (READ_BASE_LEN + {reg_n, 1'b0});
  assign value_off  = count_q - VALUE_START;
  assign value_slot = value_off[LEN_W-1:1];

  // byte role decode and frame update
  always_comb begin
    count_d     = count_q;
    crc_d       = crc_q;
    func_byte_d = func_byte_q;
    id_byte_d   = id_byte_q;
    rx_crc_d    = rx_crc_q;
    done_d      = done_q;
    hi_we       = 1'b0;
    lo_we       = 1'b0;
    count_next  = count_q;
    finish      = 1'b0;
    if (!in_data_i.func && !done_q) begin
      if (count_q < frame_len) begin
        count_next = count_q + LEN_W'(1);
        if (count_q == '0) begin
          id_byte_d = in_data_i.rx_byte;
          crc_d     = crc16_feed(crc_q, device_id_i);
        end else if (count_q == frame_len - LEN_W'(2)) begin
          rx_crc_d = {in_data_i.rx_byte, 8'h00};
        end else if (count_q == frame_len - LEN_W'(1)) begin
          rx_crc_d = rx_crc_q | {8'h00, in_data_i.rx_byte};
        end else begin
          crc_d = crc16_feed(crc_q, in_data_i.rx_byte);
          if (count_q == LEN_W'(1)) begin
            func_byte_d = in_data_i.rx_byte;
          end
          if (!response_kind_i && count_q >= VALUE_START &&
              value_slot < CNT_W'(MAX_REGISTERS)) begin
            hi_we = !value_off[0];
            lo_we = value_off[0];
          end
        end
      end
      finish  = count_next >= frame_len;
      count_d = count_next;
      if (finish) begin
        done_d = 1'b1;
      end
    end
    // end of window restarts the frame
    if (in_data_i.func) begin
      count_d     = '0;
      crc_d       = CRC_INIT;
      func_byte_d = '0;
      id_byte_d   = '0;
      rx_crc_d    = '0;
      done_d      = 1'b0;
    end
    // only an accepted word changes the frame
    if (!cmd_i.take) begin
      count_d     = count_q;
      crc_d       = crc_q;
      func_byte_d = func_byte_q;
      id_byte_d   = id_byte_q;
      rx_crc_d    = rx_crc_q;
      done_d      = done_q;
      hi_we       = 1'b0;
      lo_we       = 1'b0;
    end
  end

  // frame checks in priority order
  assign crc_wire = {crc_d[7:0], crc_d[15:8]};

  always_comb begin
    single     = 1'b0;
    multi      = 1'b0;
    res_status = ST_OK;
    res_exc    = '0;
    if (in_data_i.func) begin
      single     = !done_q;
      res_status = (count_q == '0) ? ST_TIMEOUT : ST_SHORT;
    end else if (finish) begin
      single = 1'b1;
      if (crc_wire != rx_crc_d) begin
        res_status = ST_CRC_ERR;
      end else if (id_byte_d != device_id_i) begin
        res_status = ST_WRONG_ID;
      end else if (func_byte_d > EXC_BASE && func_byte_d < EXC_LIMIT) begin
        res_status = ST_EXCEPTION;
        res_exc    = func_byte_d[3:0];
      end else if (func_byte_d != expected_function_i) begin
        res_status = ST_WRONG_FUNC;
      end else if (!response_kind_i && reg_n != '0) begin
        single = 1'b0;
        multi  = 1'b1;
      end
    end
  end

  assign status_o.single   = single;
  assign status_o.multi    = multi;
  assign status_o.idx_last = (idx_q == reg_n - CNT_W'(1));

  // value store, one ram per byte lane
  mbrc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_REGISTERS)
  ) u_ram_hi (
    .clk_i  (clk_i),
    .we_i   (hi_we),
    .waddr_i(value_slot[RAM_AW-1:0]),
    .wdata_i(in_data_i.rx_byte),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q[RAM_AW-1:0]),
    .rdata_o(hi_rd)
  );

  mbrc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_REGISTERS)
  ) u_ram_lo (
    .clk_i  (clk_i),
    .we_i   (lo_we),
    .waddr_i(value_slot[RAM_AW-1:0]),
    .wdata_i(in_data_i.rx_byte),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q[RAM_AW-1:0]),
    .rdata_o(lo_rd)
  );

  // value index counter
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  // result register load
  always_comb begin
    out_d = out_q;
    if (cmd_i.take && single) begin
      out_d.status         = res_status;
      out_d.has_value      = 1'b0;
      out_d.reg_index      = '0;
      out_d.reg_value      = '0;
      out_d.exception_code = res_exc;
      out_d.last           = 1'b1;
    end else if (cmd_i.load_value) begin
      out_d.status         = ST_OK;
      out_d.has_value      = 1'b1;
      out_d.reg_index      = idx_q[4:0];
      out_d.reg_value      = {hi_rd, lo_rd};
      out_d.exception_code = '0;
      out_d.last           = status_o.idx_last;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= CRC_INIT;
      func_byte_q <= '0;
      id_byte_q   <= '0;
      rx_crc_q    <= '0;
      done_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      count_q     <= count_d;
      crc_q       <= crc_d;
      func_byte_q <= func_byte_d;
      id_byte_q   <= id_byte_d;
      rx_crc_q    <= rx_crc_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/mbrc_ctrl.sv]
// controller of the modbus rtu response checker
// accepts words, sequences value readout and owns the result valid flag
// depends on mbrc_pkg
module mbrc_ctrl import mbrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        take;

  // result slot can be written when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = (state_q == S_IDLE) && in_valid_i && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && status_i.multi) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          state_d = status_i.idx_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.take       = take;
    cmd_o.idx_clr    = take && status_i.multi;
    cmd_o.rd_en      = (state_q == S_READ);
    cmd_o.load_value = (state_q == S_SEND) && out_free;
    cmd_o.idx_inc    = (state_q == S_SEND) && out_free && !status_i.idx_last;
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((take && status_i.single) || cmd_o.load_value) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !((state_q == S_IDLE) && out_free);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/modbus_rtu_response_checker.sv]
// Modbus RTU response checker: takes one received byte (or an end-of-window
// mark) per word and checks the response frame against the configured device
// id, function code, register count and response kind, with the Modbus CRC-16
// seeded by the device id. A byte word is taken whenever the result register
// is free and no readout runs. A frame that fails, an exception, a write echo,
// or an early window end gives one status word; a good register read gives n
// value words from the value store RAM, each by a RAM read then a result load,
// during which input stays stalled. Configuration is written through the cfg
// port, always ready, and must only change while no frame result is pending.
// depends on mbrc_pkg, mbrc_ctrl and mbrc_datapath
module modbus_rtu_response_checker import mbrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0]       device_id_q, device_id_d;
  logic [7:0]       exp_func_q, exp_func_d;
  logic [CNT_W-1:0] reg_count_q, reg_count_d;
  logic             kind_q, kind_d;
  dp_cmd_t          cmd;
  dp_status_t       dp_status;

  assign cfg_ready_o = 1'b1;

  // configuration register writes
  always_comb begin
    device_id_d = device_id_q;
    exp_func_d  = exp_func_q;
    reg_count_d = reg_count_q;
    kind_d      = kind_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_ID:         device_id_d = cfg_data_i;
        CFG_EXPECTED_FUNCTION: exp_func_d  = cfg_data_i;
        CFG_REGISTER_COUNT:    reg_count_d = cfg_data_i[CNT_W-1:0];
        CFG_RESPONSE_KIND:     kind_d      = cfg_data_i[0];
        default:               device_id_d = device_id_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= 8'd1;
      exp_func_q  <= 8'd4;
      reg_count_q <= CNT_W'(1);
      kind_q      <= 1'b0;
    end else begin
      device_id_q <= device_id_d;
      exp_func_q  <= exp_func_d;
      reg_count_q <= reg_count_d;
      kind_q      <= kind_d;
    end
  end

  // controller
  mbrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // datapath
  mbrc_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (dp_status),
    .in_data_i          (in_data_i),
    .device_id_i        (device_id_q),
    .expected_function_i(exp_func_q),
    .register_count_i   (reg_count_q),
    .response_kind_i    (kind_q),
    .out_data_o         (out_data_o)
  );

  // no input word taken while the result register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result register blocked");

  // a non-final value word means readout is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.has_value && !out_data_o.last) |-> in_stall_o)
    else $error("input accepted during value readout");

  // value words are always ok results without exception code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.has_value) |->
      (out_data_o.status == ST_OK && out_data_o.exception_code == 4'd0))
    else $error("value word with bad status");

  // exception code only accompanies an exception status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_EXCEPTION) |->
      (out_data_o.exception_code == 4'd0))
    else $error("exception code without exception status");

endmodule
